// File: rtl/ccf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_pkg
// shared constants, command and status codes, and the controller command
// struct for the closable channel fifo
// ----------------------------------------------------------------------------
package ccf_pkg;

   // storage geometry
   localparam int unsigned DEPTH      = 16;
   localparam int unsigned PTR_W      = 4;    // index into the slot store
   localparam int unsigned CNT_W      = 5;    // fill count, 0 .. DEPTH
   localparam int unsigned DATA_WIDTH = 64;
   localparam int unsigned WAIT_W     = 8;

   localparam logic [CNT_W-1:0]  DEPTH_CNT   = 5'd16;
   localparam logic [CNT_W-1:0]  CAP_RESET   = 5'd16;
   localparam logic [WAIT_W-1:0] MAX_WAITERS = 8'd255;

   // command codes
   localparam logic [2:0] CMD_SEND     = 3'd0;
   localparam logic [2:0] CMD_TRY_SEND = 3'd1;
   localparam logic [2:0] CMD_RECEIVE  = 3'd2;
   localparam logic [2:0] CMD_CLOSE    = 3'd3;
   localparam logic [2:0] CMD_ARRIVE   = 3'd4;
   localparam logic [2:0] CMD_LEAVE    = 3'd5;
   localparam logic [2:0] CMD_QUERY    = 3'd6;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_WAIT   = 2'd1;
   localparam logic [1:0] ST_CLOSED = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // take the request transfer into the input register
      logic execute;   // apply the command to the channel state
      logic load;      // move the finished result into the output register
   } dp_cmd_type;

endpackage

// File: rtl/ccf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_ctrl
// sequencer: capture, execute, then hand the result to the output register
// ----------------------------------------------------------------------------
module ccf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ccf_pkg::dp_cmd_type dp_cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dp_cmd       = '0;
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            dp_cmd.execute = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               dp_cmd.load = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accepted request goes straight to execute
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("capture not followed by execute");

   a_exec_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_DONE))
      else $error("execute not followed by done");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load |=> rsp_valid)
      else $error("loaded result not presented");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result overwrote a stalled transfer");

endmodule

// File: rtl/ccf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccf_datapath
// slot store, ring pointers, close flag, waiter count and result registers
// ----------------------------------------------------------------------------
module ccf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ccf_pkg::dp_cmd_type                 dp_cmd,
   input  logic                                csr_write_enable,
   input  logic [ccf_pkg::CNT_W-1:0]           csr_write_data,
   input  logic [2:0]                          req_command,
   input  logic [ccf_pkg::DATA_WIDTH-1:0]      req_data_in,
   output logic [1:0]                          rsp_status,
   output logic [ccf_pkg::DATA_WIDTH-1:0]      rsp_data_out,
   output logic [ccf_pkg::CNT_W-1:0]           rsp_fill_count,
   output logic                                rsp_is_closed,
   output logic                                rsp_handover_pending
);

   // slot store, no reset: a slot is read only after it was written
   logic [ccf_pkg::DATA_WIDTH-1:0] mem [ccf_pkg::DEPTH];

   // captured request
   logic [2:0]                     cmd_ff;
   logic [ccf_pkg::DATA_WIDTH-1:0] din_ff;

   // channel state
   logic [ccf_pkg::CNT_W-1:0]  cap_ff;
   logic [ccf_pkg::PTR_W-1:0]  head_ff,   head_in;
   logic [ccf_pkg::CNT_W-1:0]  held_ff,   held_in;
   logic                       closed_ff, closed_in;
   logic [ccf_pkg::WAIT_W-1:0] waiter_ff, waiter_in;

   // pending result
   logic [1:0]                     res_status_ff, res_status_in;
   logic                           res_take_ff,   res_take_in;
   logic [ccf_pkg::DATA_WIDTH-1:0] rd_data_ff;

   // output register
   logic [1:0]                     out_status_ff;
   logic [ccf_pkg::DATA_WIDTH-1:0] out_data_ff;
   logic [ccf_pkg::CNT_W-1:0]      out_fill_ff;
   logic                           out_closed_ff;
   logic                           out_hand_ff;

   logic [ccf_pkg::CNT_W-1:0] slot_total;
   logic                      handover;
   logic                      room;
   logic [ccf_pkg::CNT_W:0]   wr_sum;
   logic [ccf_pkg::CNT_W:0]   wr_wrap;
   logic [ccf_pkg::PTR_W-1:0] wr_idx;
   logic [ccf_pkg::CNT_W-1:0] head_inc;
   logic                      wr_en;
   logic                      rd_en;

   assign handover = (cap_ff == '0);
   always_comb begin
      priority if (handover) begin
         slot_total = ccf_pkg::CNT_W'(1);
      end else if (cap_ff > ccf_pkg::DEPTH_CNT) begin
         slot_total = ccf_pkg::DEPTH_CNT;
      end else begin
         slot_total = cap_ff;
      end
   end
   assign room = (held_ff < slot_total);

   // write slot: head plus fill, wrapped once at the slot total
   assign wr_sum  = {2'b00, head_ff} + {1'b0, held_ff};
   assign wr_wrap = (wr_sum >= {1'b0, slot_total}) ? (wr_sum - {1'b0, slot_total}) : wr_sum;
   assign wr_idx  = wr_wrap[ccf_pkg::PTR_W-1:0];
   assign head_inc = {1'b0, head_ff} + ccf_pkg::CNT_W'(1);

   always_comb begin
      head_in       = head_ff;
      held_in       = held_ff;
      closed_in     = closed_ff;
      waiter_in     = waiter_ff;
      res_status_in = ccf_pkg::ST_DONE;
      res_take_in   = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      unique case (cmd_ff)
         ccf_pkg::CMD_SEND: begin
            if (closed_ff) begin
               res_status_in = ccf_pkg::ST_CLOSED;
            end else if (!room) begin
               res_status_in = ccf_pkg::ST_WAIT;
            end else begin
               wr_en   = 1'b1;
               held_in = held_ff + ccf_pkg::CNT_W'(1);
            end
         end
         ccf_pkg::CMD_TRY_SEND: begin
            if (closed_ff) begin
               res_status_in = ccf_pkg::ST_CLOSED;
            end else if (!room || (handover && waiter_ff == '0)) begin
               res_status_in = ccf_pkg::ST_WAIT;
            end else begin
               wr_en   = 1'b1;
               held_in = held_ff + ccf_pkg::CNT_W'(1);
            end
         end
         ccf_pkg::CMD_RECEIVE: begin
            if (held_ff != '0) begin
               rd_en       = 1'b1;
               res_take_in = 1'b1;
               held_in     = held_ff - ccf_pkg::CNT_W'(1);
               head_in     = (head_inc >= slot_total) ? '0
                                                      : head_inc[ccf_pkg::PTR_W-1:0];
            end else if (closed_ff) begin
               res_status_in = ccf_pkg::ST_CLOSED;
            end else begin
               res_status_in = ccf_pkg::ST_WAIT;
            end
         end
         ccf_pkg::CMD_CLOSE: begin
            closed_in = 1'b1;
         end
         ccf_pkg::CMD_ARRIVE: begin
            if (waiter_ff < ccf_pkg::MAX_WAITERS) begin
               waiter_in = waiter_ff + ccf_pkg::WAIT_W'(1);
            end
         end
         ccf_pkg::CMD_LEAVE: begin
            if (waiter_ff != '0) begin
               waiter_in = waiter_ff - ccf_pkg::WAIT_W'(1);
            end
         end
         default: begin
            // query and the unused code change nothing
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff <= req_command;
         din_ff <= req_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.execute && wr_en) begin
         mem[wr_idx] <= din_ff;
      end
      if (dp_cmd.execute && rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= ccf_pkg::CAP_RESET;
         head_ff   <= '0;
         held_ff   <= '0;
         closed_ff <= 1'b0;
         waiter_ff <= '0;
      end else if (csr_write_enable) begin
         cap_ff    <= csr_write_data;
         head_ff   <= '0;
         held_ff   <= '0;
         closed_ff <= 1'b0;
         waiter_ff <= '0;
      end else if (dp_cmd.execute) begin
         head_ff   <= head_in;
         held_ff   <= held_in;
         closed_ff <= closed_in;
         waiter_ff <= waiter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         res_status_ff <= res_status_in;
         res_take_ff   <= res_take_in;
      end
   end

   // state registers already hold the post-command values when the result loads
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         out_status_ff <= res_status_ff;
         out_data_ff   <= res_take_ff ? rd_data_ff : '0;
         out_fill_ff   <= held_ff;
         out_closed_ff <= closed_ff;
         out_hand_ff   <= handover && (held_ff != '0) && !closed_ff;
      end
   end

   assign rsp_status           = out_status_ff;
   assign rsp_data_out         = out_data_ff;
   assign rsp_fill_count       = out_fill_ff;
   assign rsp_is_closed        = out_closed_ff;
   assign rsp_handover_pending = out_hand_ff;

endmodule

// File: rtl/closable_channel_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closable_channel_fifo_top
// bounded ring-buffer channel with close flag, waiter count and handover mode
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake          | payload
//  -----------+-----------+--------------------+---------------------------------
//  req_       | in        | req_valid/stall    | command, data_in
//  rsp_       | out       | rsp_valid/stall    | status, data_out, fill_count,
//             |           |                    | is_closed, handover_pending
//  csr_       | in        | csr_write_enable   | capacity (5 bits)
//
//  - each command runs capture, execute (slot store access and state update),
//    then result load; the registered slot read sets the middle step
//  - a new request is taken once the previous result has moved to the output
//    register; while a response stalls, one more command runs up to its
//    result load, then the request side stalls until the output frees
//  - reset is synchronous: capacity 16, channel open, empty, no waiters;
//    slot data has no reset and no clearing pass
//  - a capacity write re-opens and empties the channel
//
module closable_channel_fifo_top (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_command,
   input  logic [ccf_pkg::DATA_WIDTH-1:0] req_data_in,

   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [ccf_pkg::DATA_WIDTH-1:0] rsp_data_out,
   output logic [ccf_pkg::CNT_W-1:0]      rsp_fill_count,
   output logic                           rsp_is_closed,
   output logic                           rsp_handover_pending,

   // capacity register
   input  logic                           csr_write_enable,
   input  logic [ccf_pkg::CNT_W-1:0]      csr_write_data
);

   ccf_pkg::dp_cmd_type dp_cmd;

   // sequencer: one command in flight at a time
   ccf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // storage, pointers and result registers
   ccf_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .dp_cmd               (dp_cmd),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_command          (req_command),
      .req_data_in          (req_data_in),
      .rsp_status           (rsp_status),
      .rsp_data_out         (rsp_data_out),
      .rsp_fill_count       (rsp_fill_count),
      .rsp_is_closed        (rsp_is_closed),
      .rsp_handover_pending (rsp_handover_pending)
   );

endmodule

// File: tb/closable_channel_fifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closable_channel_fifo_checker
// watches the request, response and capacity ports, keeps its own model of
// the channel, and compares every response transfer field by field
// ----------------------------------------------------------------------------
module closable_channel_fifo_checker (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [2:0]                     req_command,
   input  logic [ccf_pkg::DATA_WIDTH-1:0] req_data_in,

   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [ccf_pkg::DATA_WIDTH-1:0] rsp_data_out,
   input  logic [ccf_pkg::CNT_W-1:0]      rsp_fill_count,
   input  logic                           rsp_is_closed,
   input  logic                           rsp_handover_pending,

   input  logic                           csr_write_enable,
   input  logic [ccf_pkg::CNT_W-1:0]      csr_write_data,

   output int                             fail_count,
   output int                             pending_count,
   output int                             results_checked,
   output int                             values_taken
);

   import ccf_pkg::*;

   typedef struct packed {
      logic [1:0]            status;
      logic [DATA_WIDTH-1:0] data_out;
      logic [CNT_W-1:0]      fill_count;
      logic                  is_closed;
      logic                  handover_pending;
   } channel_result_type;

   // model of the channel
   logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
   int unsigned           head_ptr;
   int unsigned           held_cnt;
   int unsigned           waiter_cnt;
   logic                  chan_closed;
   logic [CNT_W-1:0]      capacity_reg;

   channel_result_type    expected_q [$];
   int                    errors;
   int                    checked;
   int                    taken;

   // zero selects handover with one slot, anything above the store saturates
   function automatic int unsigned slots_in_use(input logic [CNT_W-1:0] cap);
      if (cap == '0) return 1;
      if (cap > DEPTH_CNT) return DEPTH;
      return cap;
   endfunction

   task automatic clear_channel();
      head_ptr    = 0;
      held_cnt    = 0;
      waiter_cnt  = 0;
      chan_closed = 1'b0;
   endtask

   task automatic predict_result(input logic [2:0] cmd, input logic [DATA_WIDTH-1:0] din,
                                 output channel_result_type res);
      int unsigned total;
      int unsigned wr_at;
      logic        handover;
      logic        room;
      total    = slots_in_use(capacity_reg);
      handover = (capacity_reg == '0);
      room     = (held_cnt < total);
      res        = '0;
      res.status = ST_DONE;
      case (cmd)
         CMD_SEND, CMD_TRY_SEND: begin
            if (chan_closed) begin
               res.status = ST_CLOSED;
            end else if (!room || (cmd == CMD_TRY_SEND && handover && waiter_cnt == 0)) begin
               res.status = ST_WAIT;
            end else begin
               wr_at = head_ptr + held_cnt;
               if (wr_at >= total) wr_at -= total;
               slot_mem[wr_at] = din;
               held_cnt++;
            end
         end
         CMD_RECEIVE: begin
            if (held_cnt > 0) begin
               res.data_out = slot_mem[head_ptr];
               head_ptr     = (head_ptr + 1 >= total) ? 0 : head_ptr + 1;
               held_cnt--;
            end else if (chan_closed) begin
               res.status = ST_CLOSED;
            end else begin
               res.status = ST_WAIT;
            end
         end
         CMD_CLOSE:  chan_closed = 1'b1;
         CMD_ARRIVE: if (waiter_cnt < MAX_WAITERS) waiter_cnt++;
         CMD_LEAVE:  if (waiter_cnt > 0) waiter_cnt--;
         default: ;  // query and the spare code change nothing
      endcase
      res.fill_count       = held_cnt[CNT_W-1:0];
      res.is_closed        = chan_closed;
      res.handover_pending = handover && held_cnt > 0 && !chan_closed;
   endtask

   task automatic check_field(input string field, input logic [DATA_WIDTH-1:0] want,
                              input logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      channel_result_type want;
      if (reset) begin
         capacity_reg = CAP_RESET;
         clear_channel();
         expected_q.delete();
      end else begin
         if (csr_write_enable) begin
            capacity_reg = csr_write_data;
            clear_channel();
         end
         // response first, so a transfer can never be matched to a same-cycle request
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_q.size() == 0) begin
               $error("response transfer with no command outstanding");
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("data_out", want.data_out, rsp_data_out);
               check_field("fill_count", want.fill_count, rsp_fill_count);
               check_field("is_closed", want.is_closed, rsp_is_closed);
               check_field("handover_pending", want.handover_pending, rsp_handover_pending);
            end
         end
         if (req_valid && !req_stall) begin
            predict_result(req_command, req_data_in, want);
            if (req_command == CMD_RECEIVE && want.status == ST_DONE) taken++;
            expected_q.push_back(want);
         end
      end
      fail_count      <= errors;
      pending_count   <= expected_q.size();
      results_checked <= checked;
      values_taken    <= taken;
   end

endmodule

// File: tb/closable_channel_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closable_channel_fifo_top_tb
// drives commands and capacity settings into the closable channel fifo and
// lets the checker compare each response against its own channel model
// ----------------------------------------------------------------------------
module closable_channel_fifo_top_tb;

   import ccf_pkg::*;

   // command seven is spare and behaves as a query
   localparam logic [2:0] CMD_SPARE = 3'd7;

   // traffic mixes for the random phases
   localparam int FLAVOR_MIXED      = 0;
   localparam int FLAVOR_FILL       = 1;
   localparam int FLAVOR_DRAIN      = 2;
   localparam int FLAVOR_RENDEZVOUS = 3;

   // receiver stall behaviors
   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   localparam int ITEM_TARGET = 1450;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [2:0]            req_command;
   logic [DATA_WIDTH-1:0] req_data_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_status;
   logic [DATA_WIDTH-1:0] rsp_data_out;
   logic [CNT_W-1:0]      rsp_fill_count;
   logic                  rsp_is_closed;
   logic                  rsp_handover_pending;
   logic                  csr_write_enable;
   logic [CNT_W-1:0]      csr_write_data;

   int fail_count;
   int pending_count;
   int results_checked;
   int values_taken;

   int items_sent;
   int settings_used;
   int burst_left;

   closable_channel_fifo_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_data_in          (req_data_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_data_out         (rsp_data_out),
      .rsp_fill_count       (rsp_fill_count),
      .rsp_is_closed        (rsp_is_closed),
      .rsp_handover_pending (rsp_handover_pending),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   // the checker sees exactly what the block sees
   closable_channel_fifo_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_data_in          (req_data_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_data_out         (rsp_data_out),
      .rsp_fill_count       (rsp_fill_count),
      .rsp_is_closed        (rsp_is_closed),
      .rsp_handover_pending (rsp_handover_pending),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .fail_count           (fail_count),
      .pending_count        (pending_count),
      .results_checked      (results_checked),
      .values_taken         (values_taken)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #6000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [DATA_WIDTH-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // one request transfer; the sender works in bursts, and the gap before a new
   // burst is taken here so that idle cycles land on every phase of the block
   task automatic issue(input logic [2:0] cmd, input logic [DATA_WIDTH-1:0] din);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_data_in <= din;
      // payload holds until the transfer goes through
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // sender stops until every predicted response has been taken
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // only called with the channel idle
   task automatic write_capacity(input logic [CNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // send and receive take most of the mix; fill and drain tilt the balance
   function automatic logic [2:0] pick_command(input int flavor);
      int r;
      int send_w;
      send_w = (flavor == FLAVOR_FILL) ? 45 : (flavor == FLAVOR_DRAIN) ? 10 : 28;
      r = $urandom_range(0, 99);
      if (r < send_w) return CMD_SEND;
      r -= send_w;
      if (r < 15) return CMD_TRY_SEND;
      r -= 15;
      if (r < 60 - send_w) return CMD_RECEIVE;
      r -= 60 - send_w;
      if (r < 8) return CMD_ARRIVE;
      r -= 8;
      if (r < 7) return CMD_LEAVE;
      r -= 7;
      if (r < 5) return CMD_QUERY;
      r -= 5;
      if (r < 4) return CMD_SPARE;
      return CMD_CLOSE;
   endfunction

   function automatic logic [CNT_W-1:0] pick_capacity(input int flavor);
      if (flavor == FLAVOR_RENDEZVOUS || $urandom_range(0, 7) == 0) return '0;
      case ($urandom_range(0, 5))
         0:       return 5'd1;
         1:       return DEPTH_CNT;
         2:       return 5'd31;                        // all ones, acts as sixteen slots
         3:       return DEPTH_CNT + CNT_W'($urandom_range(1, 14));
         default: return CNT_W'($urandom_range(2, 15));
      endcase
   endfunction

   // one setting's worth of traffic, closed part way through about half the time
   task automatic run_phase(input int flavor, input int count);
      int close_at;
      int k;
      close_at = ($urandom_range(0, 1) == 1) ? $urandom_range(count * 2 / 3, count - 1) : -1;
      k = 0;
      while (k < count) begin
         if (close_at >= 0 && k >= close_at) begin
            issue(CMD_CLOSE, random_word());
            close_at = -1;
            k++;
         end else if (flavor == FLAVOR_RENDEZVOUS && $urandom_range(0, 4) != 0) begin
            // receiver shows up, value handed over, receiver goes away
            issue(CMD_ARRIVE, random_word());
            issue(($urandom_range(0, 3) != 0) ? CMD_TRY_SEND : CMD_SEND, random_word());
            issue(CMD_RECEIVE, random_word());
            issue(CMD_LEAVE, random_word());
            k += 4;
         end else begin
            issue(pick_command(flavor), random_word());
            k++;
         end
      end
   endtask

   // receiver stall pattern, independent of the sender
   initial begin
      int mode;
      int run_len;
      rsp_stall <= 1'b0;
      forever begin
         mode    = $urandom_range(STALL_NONE, STALL_PERIODIC);
         run_len = $urandom_range(16, 160);
         for (int c = 0; c < run_len; c++) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
               default:     rsp_stall <= ((c % 12) >= 8);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int flavor;
      req_valid        <= 1'b0;
      req_command      <= CMD_QUERY;
      req_data_in      <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      items_sent    = 0;
      settings_used = 0;
      burst_left    = 0;

      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: plain buffered channel
      issue(CMD_QUERY, '0);
      issue(CMD_SPARE, '1);
      issue(CMD_RECEIVE, '0);                          // empty and open: must wait
      issue(CMD_SEND, '0);
      issue(CMD_SEND, '1);
      issue(CMD_TRY_SEND, 64'hA5A5_5A5A_0F0F_F0F0);    // no waiter needed when buffered
      issue(CMD_RECEIVE, '1);
      issue(CMD_RECEIVE, '0);
      issue(CMD_LEAVE, '0);                            // leave with nobody waiting
      issue(CMD_ARRIVE, '0);
      issue(CMD_LEAVE, '0);
      issue(CMD_CLOSE, '0);
      issue(CMD_CLOSE, '0);                            // second close is harmless
      issue(CMD_SEND, random_word());                  // refused, closed
      issue(CMD_TRY_SEND, random_word());
      issue(CMD_RECEIVE, '0);                          // closed still yields what it holds
      issue(CMD_RECEIVE, '0);                          // then reports closed

      // handover mode
      wait_until_drained();
      write_capacity('0);
      issue(CMD_TRY_SEND, random_word());              // no receiver waiting
      issue(CMD_SEND, 64'h0000_0000_0000_0001);
      issue(CMD_SEND, random_word());                  // single slot already taken
      issue(CMD_RECEIVE, '0);
      issue(CMD_ARRIVE, '0);
      issue(CMD_TRY_SEND, 64'h8000_0000_0000_0000);
      issue(CMD_CLOSE, '0);                            // pending flag drops on close
      issue(CMD_RECEIVE, '0);

      // push the waiter count into saturation, then walk it back down: if it
      // saturated at the limit, the second try_send must wait
      wait_until_drained();
      write_capacity('0);
      repeat (int'(MAX_WAITERS) + 3) issue(CMD_ARRIVE, random_word());
      repeat (int'(MAX_WAITERS) - 1) issue(CMD_LEAVE, random_word());
      issue(CMD_TRY_SEND, random_word());
      issue(CMD_RECEIVE, '0);
      issue(CMD_LEAVE, random_word());
      issue(CMD_TRY_SEND, random_word());
      issue(CMD_LEAVE, random_word());

      // capacity all ones fills up at sixteen
      wait_until_drained();
      write_capacity(5'd31);
      run_phase(FLAVOR_FILL, 60);

      // random phases, each with its own setting and mix
      while (items_sent < ITEM_TARGET) begin
         flavor = $urandom_range(FLAVOR_MIXED, FLAVOR_RENDEZVOUS);
         wait_until_drained();
         write_capacity(pick_capacity(flavor));
         run_phase(flavor, $urandom_range(30, 120));
      end

      wait_until_drained();
      // room for any stray response after the last one expected
      repeat (20) @(posedge clock);

      $display("%0d commands over %0d capacity settings, %0d responses checked",
               items_sent, settings_used, results_checked);
      $display("%0d values received, handover, close and waiter saturation exercised",
               values_taken);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ccf_pkg.sv
rtl/ccf_ctrl.sv
rtl/ccf_datapath.sv
rtl/closable_channel_fifo_top.sv
tb/closable_channel_fifo_checker.sv
tb/closable_channel_fifo_top_tb.sv
